// ===== hw/rtl/stq_pkg.sv =====
// Types and constants shared by the sorted timer queue.
// No dependencies; compiled before all other files.
package stq_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned IdW   = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned ThrW  = 16;

  localparam logic [ThrW-1:0] THRESHOLD_RESET = 16'd30;

  // Configuration register byte addresses
  localparam logic [1:0] REG_THRESHOLD = 2'd0;

  // Result status codes
  localparam logic STATUS_FIRED   = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2
  } stq_op_t;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_FIRE
  } stq_state_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_REMOVE,
    CMD_INSERT,
    CMD_POP
  } stq_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   owner;
  } stq_entry_t;

  localparam stq_entry_t ENTRY_EMPTY = '{valid: 1'b0, deadline: '0, owner: '0};

  typedef struct packed {
    stq_cmd_t         cmd;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] offset;
    stq_entry_t       new_entry;
  } stq_ctrl_t;

endpackage

// ===== hw/rtl/stq_if.sv =====
// Handshake channels of the sorted timer queue: request and result beats.
// Depends on nothing; compiled after stq_pkg.
interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  timer_id;
  logic [31:0] offset_low;
  logic [31:0] offset_high;

  modport source (output valid, operation, timer_id, offset_low, offset_high, input ready);
  modport sink   (input valid, operation, timer_id, offset_low, offset_high, output ready);
endinterface

interface stq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] fired_id;
  logic       status;
  logic       last;

  modport source (output valid, fired_id, status, last, input ready);
  modport sink   (input valid, fired_id, status, last, output ready);
endinterface

// ===== hw/rtl/sorted_timer_queue_top.sv =====
// Sorted timer queue: request beats in, fired/dropped results out, APB config.
// Per beat: tick fires due timers, set removes then inserts, remove removes;
// a new beat is taken only in idle. In a firing burst, one result per cycle
// while out_chan is ready, paced by the chain (one slot operation per cycle).
// Reset (rst_n low, synchronous): time 0, queue empty, threshold 30.
// Depends on stq_pkg, stq_if and stq_cell.
module sorted_timer_queue_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stq_in_if.sink      in_chan,
  stq_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stq_pkg::*;

  stq_state_t       state_r, state_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [1:0]       op_r;
  logic [IdW-1:0]   id_r;
  logic [TimeW-1:0] offset_r;
  logic             imm_r;
  logic [ThrW-1:0]  thr_r;

  logic             out_valid_r;
  logic [IdW-1:0]   out_id_r;
  logic             out_status_r;
  logic             out_last_r;

  logic             in_acc, out_free, out_load;
  logic [IdW-1:0]   res_id;
  logic             res_status, res_last;
  logic             now_inc;
  logic [TimeW-1:0] now_plus1;
  logic             due0, due1, full;
  stq_ctrl_t        ctrl;
  stq_cmd_t         cmd;

  stq_entry_t       ent [SLOTS];
  logic             rm_chain [SLOTS];
  logic             gt_chain [SLOTS];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_THRESHOLD) ? {{(32-ThrW){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      thr_r <= cfg_pwdata[ThrW-1:0];
    end
  end

  // handshakes
  assign in_chan.ready     = (state_r == ST_IDLE);
  assign in_acc            = in_chan.valid & in_chan.ready;
  assign out_free          = !out_valid_r | out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.fired_id = out_id_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.last     = out_last_r;

  // due tests on the head and its successor
  assign now_plus1 = now_r + {{(TimeW-1){1'b0}}, 1'b1};
  assign due0 = ent[0].valid & ((ent[0].deadline == now_r) | (ent[0].deadline == now_plus1));
  assign due1 = ent[1].valid & ((ent[1].deadline == now_r) | (ent[1].deadline == now_plus1));
  assign full = ent[SLOTS-1].valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.operation)
            OP_TICK:   state_nxt = ST_FIRE;
            OP_SET:    state_nxt = ST_REMOVE;
            OP_REMOVE: state_nxt = ST_REMOVE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REMOVE: state_nxt = (op_r == OP_SET) ? ST_INSERT : ST_IDLE;
      ST_INSERT: begin
        if ((imm_r | full) && !out_free) state_nxt = ST_INSERT;
        else                             state_nxt = ST_IDLE;
      end
      ST_FIRE: begin
        if (!due0)                 state_nxt = ST_IDLE;
        else if (out_free && !due1) state_nxt = ST_IDLE;
        else                        state_nxt = ST_FIRE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd        = CMD_HOLD;
    out_load   = 1'b0;
    res_id     = id_r;
    res_status = STATUS_FIRED;
    res_last   = 1'b1;
    now_inc    = 1'b0;
    case (state_r)
      ST_REMOVE: cmd = CMD_REMOVE;
      ST_INSERT: begin
        if (imm_r | full) begin
          out_load   = out_free;
          res_status = imm_r ? STATUS_FIRED : STATUS_DROPPED;
        end else begin
          cmd = CMD_INSERT;
        end
      end
      ST_FIRE: begin
        if (!due0) begin
          now_inc = 1'b1;
        end else if (out_free) begin
          cmd      = CMD_POP;
          out_load = 1'b1;
          res_id   = ent[0].owner;
          res_last = !due1;
          now_inc  = !due1;
        end
      end
      default: cmd = CMD_HOLD;
    endcase
  end

  assign now_nxt = now_inc ? now_plus1 : now_r;

  assign ctrl = '{
    cmd:       cmd,
    id:        id_r,
    now:       now_r,
    offset:    offset_r,
    new_entry: '{valid: 1'b1, deadline: now_r + offset_r, owner: id_r}
  };

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // captured request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_chan.operation;
      id_r     <= in_chan.timer_id;
      offset_r <= {in_chan.offset_high, in_chan.offset_low};
      imm_r    <= (in_chan.offset_high == '0) &&
                  (in_chan.offset_low < {{(WordW-ThrW){1'b0}}, thr_r});
    end
    if (out_load) begin
      out_id_r     <= res_id;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  // chain of slots, head at index 0
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    stq_entry_t left_ent, right_ent;
    logic       rm_in, gt_in;

    if (i == 0) begin : g_head
      assign left_ent = ENTRY_EMPTY;
      assign rm_in    = 1'b0;
      assign gt_in    = 1'b0;
    end else begin : g_body
      assign left_ent = ent[i-1];
      assign rm_in    = rm_chain[i-1];
      assign gt_in    = gt_chain[i-1];
    end

    if (i == SLOTS-1) begin : g_tail
      assign right_ent = ENTRY_EMPTY;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .rm_in     (rm_in),
      .gt_in     (gt_in),
      .ent       (ent[i]),
      .rm_out    (rm_chain[i]),
      .gt_out    (gt_chain[i])
    );
  end

endmodule

// ===== hw/rtl/stq_cell.sv =====
// One slot of the sorted timer chain: holds an entry and trades it with
// its neighbours on remove, insert and pop. Depends on stq_pkg.
module stq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::stq_ctrl_t  ctrl,
  input  stq_pkg::stq_entry_t left_ent,
  input  stq_pkg::stq_entry_t right_ent,
  input  logic                rm_in,
  input  logic                gt_in,
  output stq_pkg::stq_entry_t ent,
  output logic                rm_out,
  output logic                gt_out
);
  import stq_pkg::*;

  logic             valid_r, valid_nxt;
  logic [TimeW-1:0] deadline_r, deadline_nxt;
  logic [IdW-1:0]   owner_r, owner_nxt;
  logic [TimeW-1:0] remaining;
  logic             gt_here;
  stq_entry_t       take;

  assign ent = '{valid: valid_r, deadline: deadline_r, owner: owner_r};

  // removal point ripples towards the tail
  assign rm_out = rm_in | (valid_r & (owner_r == ctrl.id));

  // insertion boundary: first slot whose remaining time exceeds the offset
  assign remaining = deadline_r - ctrl.now;
  assign gt_here   = !valid_r | (remaining > ctrl.offset);
  assign gt_out    = gt_here;

  always_comb begin
    take = ent;
    case (ctrl.cmd)
      CMD_REMOVE: begin
        if (rm_out) take = right_ent;
      end
      CMD_INSERT: begin
        if (gt_here) take = gt_in ? left_ent : ctrl.new_entry;
      end
      CMD_POP:    take = right_ent;
      default:    take = ent;
    endcase
    valid_nxt    = take.valid;
    deadline_nxt = take.deadline;
    owner_nxt    = take.owner;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    owner_r    <= owner_nxt;
  end

endmodule
